/* rtl/core/dspe_pkg.sv */
package dspe_pkg;

  localparam int POSITION_BITS_DEF   = 40;
  localparam int MZ_SEARCH_START_DEF = 512;

  localparam int KEY_BITS      = 56;
  localparam int KEY_LEN_BITS  = 4;
  localparam int FALLBACK_BITS = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int SPLIT_BITS    = 40;
  localparam int HDR_COPY_BYTES = 64;

  localparam logic [KEY_BITS-1:0]      KEY_RESET      = 56'h8C80E28B80E2A0;
  localparam logic [KEY_LEN_BITS-1:0]  KEY_LEN_RESET  = 4'd7;
  localparam logic [FALLBACK_BITS-1:0] FALLBACK_RESET = 2'd0;

  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_LEN  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FALLBACK = 2'd2;

  localparam logic [FALLBACK_BITS-1:0] FB_MZ_WHOLE = 2'd0;
  localparam logic [FALLBACK_BITS-1:0] FB_MZ_HALF  = 2'd1;
  localparam logic [FALLBACK_BITS-1:0] FB_FAIL     = 2'd2;
  localparam logic [FALLBACK_BITS-1:0] FB_RESERVED = 2'd3;

  localparam logic [1:0] SRC_PE   = 2'd0;
  localparam logic [1:0] SRC_MZ   = 2'd1;
  localparam logic [1:0] SRC_SIZE = 2'd2;
  localparam logic [1:0] SRC_FAIL = 2'd3;

  localparam logic [1:0] SIG_PENDING  = 2'd0;
  localparam logic [1:0] SIG_MATCH    = 2'd1;
  localparam logic [1:0] SIG_MISMATCH = 2'd2;

  typedef struct packed {
    logic accept;
    logic replay;
    logic load63;
    logic fin1;
    logic fin2;
  } cmd_t;

  typedef struct packed {
    logic pos63;
    logic last_seen;
    logic replay_done;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/dspe_if.sv */
interface dspe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dspe_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  plain_byte;
  logic        stream_done;
  logic [39:0] split_point;
  logic [1:0]  split_source;
  modport source (output valid, output plain_byte, output stream_done, output split_point,
                  output split_source, input ready);
  modport sink (input valid, input plain_byte, input stream_done, input split_point,
                input split_source, output ready);
endinterface

/* rtl/core/descramble_and_pe_split_finder_unit.sv */
// Descrambles a byte stream with a repeating key of up to seven bytes and returns one
// plain byte per request, at one request per cycle while idle with the output free. The
// plain bytes are parsed as a PE image; the result of the last byte carries the split
// point and its source. The first 64 bytes are kept in a small RAM and replayed
// through the field capture after byte 63, stalling the input as does the last byte's
// length decision. The user writes configuration via the plain write port while idle.
module descramble_and_pe_split_finder_unit #(
  parameter int POSITION_BITS   = dspe_pkg::POSITION_BITS_DEF,
  parameter int MZ_SEARCH_START = dspe_pkg::MZ_SEARCH_START_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_we,
  input logic [dspe_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input logic [dspe_pkg::KEY_BITS-1:0]     cfg_data,
  dspe_in_if.sink                          din,
  dspe_out_if.source                       dout
);
  import dspe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dspe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_last  (din.last_byte),
    .in_ready (din.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dspe_dp #(
    .POSITION_BITS   (POSITION_BITS),
    .MZ_SEARCH_START (MZ_SEARCH_START)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (din.data_byte),
    .in_last    (din.last_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (dout.ready),
    .out_valid  (dout.valid),
    .out_plain  (dout.plain_byte),
    .out_done   (dout.stream_done),
    .out_split  (dout.split_point),
    .out_source (dout.split_source)
  );
endmodule

/* rtl/core/dspe_ram.sv */
module dspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/dspe_ctrl.sv */
module dspe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  dspe_pkg::stat_t stat,
  output dspe_pkg::cmd_t  cmd
);
  import dspe_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REPLAY = 3'd1;
  localparam logic [2:0] S_HOLD63 = 3'd2;
  localparam logic [2:0] S_FIN1   = 3'd3;
  localparam logic [2:0] S_FIN2   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       acc;

  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign acc      = in_ready && in_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = acc;
        if (acc) begin
          if (stat.pos63) begin
            state_next = S_REPLAY;
          end else if (in_last) begin
            state_next = S_FIN1;
          end
        end
      end
      S_REPLAY: begin
        cmd.replay = 1'b1;
        if (stat.replay_done) begin
          state_next = stat.last_seen ? S_FIN1 : S_HOLD63;
        end
      end
      S_HOLD63: begin
        if (stat.out_free) begin
          cmd.load63 = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIN1: begin
        cmd.fin1   = 1'b1;
        state_next = S_FIN2;
      end
      S_FIN2: begin
        if (stat.out_free) begin
          cmd.fin2   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* rtl/core/dspe_dp.sv */
module dspe_dp #(
  parameter int POSITION_BITS   = dspe_pkg::POSITION_BITS_DEF,
  parameter int MZ_SEARCH_START = dspe_pkg::MZ_SEARCH_START_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dspe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [dspe_pkg::KEY_BITS-1:0]       cfg_data,
  input  logic [7:0]                          in_data,
  input  logic                                in_last,
  input  dspe_pkg::cmd_t                      cmd,
  output dspe_pkg::stat_t                     stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [7:0]                          out_plain,
  output logic                                out_done,
  output logic [dspe_pkg::SPLIT_BITS-1:0]     out_split,
  output logic [1:0]                          out_source
);
  import dspe_pkg::*;

  localparam int P = POSITION_BITS;
  localparam int W = (P > 35 ? P : 35) + 1;
  localparam logic [P-1:0] POS_HOLD = {{(P-1){1'b1}}, 1'b0};
  localparam logic [P-1:0] MZ_FIRST = P'(MZ_SEARCH_START + 1);

  function automatic logic [31:0] put_byte(logic [31:0] v, logic [1:0] k, logic [7:0] b);
    logic [31:0] r;
    r = v;
    r[8*k +: 8] = b;
    return r;
  endfunction

  logic [KEY_BITS-1:0]      key;
  logic [KEY_LEN_BITS-1:0]  klen;
  logic [FALLBACK_BITS-1:0] fallback;

  logic [P-1:0]  bpos;
  logic [2:0]    kidx;
  logic [31:0]   hoff;
  logic [1:0]    sig;
  logic [15:0]   scnt;
  logic [15:0]   ohs;
  logic [31:0]   hsz;
  logic [31:0]   rsz;
  logic [31:0]   rptr;
  logic [33:0]   lse;
  logic [P-1:0]  mzpos;
  logic [7:0]    prev;
  logic          b0m;
  logic          dos_pair;
  logic          dos_ok;
  logic          tbl_on;
  logic [5:0]    tr;
  logic [15:0]   te;
  logic          last_r;
  logic [7:0]    plain_r;
  logic [6:0]    rq;
  logic          rd_vld;
  logic [5:0]    cap_q;
  logic [7:0]    ram_rdata;
  logic          f_pe6_bad;
  logic          f_hs_room;
  logic [34:0]   f_hend;

  logic [3:0]  len;
  logic [3:0]  idx;
  logic [3:0]  idx_next;
  logic [7:0]  kb;
  logic [7:0]  plain;
  logic        low_pos;
  logic        cap_en;
  logic [P-1:0] cap_p;
  logic [7:0]  cap_b;
  logic [P:0]  dpe;
  logic        near;
  logic [6:0]  d7;
  logic [33:0] st;
  logic        at_st;
  logic        t_in;
  logic [5:0]  t_r;
  logic [15:0] t_e;
  logic        row_ok;
  logic [31:0] rptr_new;
  logic [32:0] sec_end;
  logic        mz_hit;
  logic [P-1:0] size;
  logic        pe_ok;
  logic        plen_ok;
  logic [34:0] plen;
  logic [W-1:0] split;
  logic [1:0]  src;

  always_comb begin
    len     = (klen > 4'd8) ? 4'd8 : klen;
    idx     = ({1'b0, kidx} < len) ? {1'b0, kidx} : 4'd0;
    idx_next = (idx + 4'd1 >= len) ? 4'd0 : idx + 4'd1;
    kb      = (len != 4'd0 && idx < 4'd7) ? key[8*idx[2:0] +: 8] : 8'd0;
    plain   = in_data ^ kb;
    low_pos = (bpos < P'(HDR_COPY_BYTES));
    mz_hit  = (prev == 8'h4D) && (plain == 8'h5A) && (bpos >= MZ_FIRST) && (mzpos == '0);
  end

  always_comb begin
    cap_en = rd_vld || (cmd.accept && !low_pos);
    cap_p  = rd_vld ? P'(cap_q) : bpos;
    cap_b  = rd_vld ? ram_rdata : plain;
    dpe    = {1'b0, cap_p} - (P + 1)'(hoff);
    near   = !dpe[P] && (dpe[P-1:0] < P'(88));
    d7     = dpe[6:0];
    st     = 34'(hoff) + 34'(24) + 34'(ohs);
    at_st  = (cap_p == P'(st));
    t_in   = at_st || tbl_on;
    t_r    = at_st ? 6'd0 : tr;
    t_e    = at_st ? 16'd0 : te;
    row_ok = t_in && (t_e < scnt);
    rptr_new = put_byte(rptr, 2'(t_r - 6'd20), cap_b);
    sec_end  = 33'(rptr_new) + 33'(rsz);
  end

  always_comb begin
    size    = bpos + P'(1);
    pe_ok   = dos_ok && !f_pe6_bad && (sig == SIG_MATCH) && (W'(f_hend) <= W'(size));
    plen    = '0;
    plen_ok = 1'b0;
    if (pe_ok) begin
      if (lse != '0) begin
        plen    = (35'(lse) > f_hend) ? 35'(lse) : f_hend;
        plen_ok = 1'b1;
      end else if (f_hs_room && hsz != '0) begin
        plen    = 35'(hsz);
        plen_ok = 1'b1;
      end
    end
    if (plen_ok && (W'(plen) < W'(size))) begin
      split = W'(plen);
      src   = SRC_PE;
    end else if (fallback == FB_MZ_WHOLE || fallback == FB_MZ_HALF) begin
      if (mzpos != '0) begin
        split = W'(mzpos);
        src   = SRC_MZ;
      end else begin
        split = (fallback == FB_MZ_WHOLE) ? W'(size) : W'(size >> 1);
        src   = SRC_SIZE;
      end
    end else begin
      split = '0;
      src   = SRC_FAIL;
    end
  end

  dspe_ram #(.WIDTH(8), .DEPTH(HDR_COPY_BYTES)) u_copy (
    .clk   (clk),
    .we    (cmd.accept && low_pos),
    .waddr (bpos[5:0]),
    .wdata (plain),
    .raddr (rq[5:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.pos63       = (bpos == P'(63));
    stat.last_seen   = last_r;
    stat.replay_done = rd_vld && (cap_q == 6'd63);
    stat.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key      <= KEY_RESET;
      klen     <= KEY_LEN_RESET;
      fallback <= FALLBACK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY:      key      <= cfg_data;
        CFG_KEY_LEN:  klen     <= cfg_data[KEY_LEN_BITS-1:0];
        CFG_FALLBACK: fallback <= cfg_data[FALLBACK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq     <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.replay && !rq[6];
      if (stat.replay_done) begin
        rq <= '0;
      end else if (cmd.replay && !rq[6]) begin
        rq <= rq + 7'd1;
      end
    end
    cap_q <= rq[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.accept && !in_last && !stat.pos63) begin
      out_valid <= 1'b1;
    end else if (cmd.load63 || cmd.fin2) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.accept) begin
      out_plain  <= plain;
      out_done   <= 1'b0;
      out_split  <= '0;
      out_source <= SRC_PE;
    end else if (cmd.load63) begin
      out_plain <= plain_r;
    end else if (cmd.fin2) begin
      out_plain  <= plain_r;
      out_done   <= 1'b1;
      out_split  <= SPLIT_BITS'(split);
      out_source <= src;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      f_pe6_bad <= (W'(hoff) + W'(6)) > W'(size);
      f_hs_room <= (W'(hoff) + W'(88)) <= W'(size);
      f_hend    <= 35'(hoff) + 35'(24) + 35'(ohs) + (35'(scnt) << 5) + (35'(scnt) << 3);
    end
    if (cmd.accept) begin
      plain_r <= plain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.fin2) begin
      bpos     <= '0;
      kidx     <= '0;
      hoff     <= '0;
      sig      <= SIG_PENDING;
      scnt     <= '0;
      ohs      <= '0;
      hsz      <= '0;
      rsz      <= '0;
      rptr     <= '0;
      lse      <= '0;
      mzpos    <= '0;
      prev     <= '0;
      b0m      <= 1'b0;
      dos_pair <= 1'b0;
      dos_ok   <= 1'b0;
      tbl_on   <= 1'b0;
      tr       <= '0;
      te       <= '0;
      last_r   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_r <= in_last;
        prev   <= plain;
        if (len != 4'd0) begin
          kidx <= idx_next[2:0];
        end
        if (!in_last && bpos < POS_HOLD) begin
          bpos <= bpos + P'(1);
        end
        if (mz_hit) begin
          mzpos <= bpos - P'(1);
        end
        if (bpos == P'(0)) begin
          b0m <= (plain == 8'h4D);
        end
        if (bpos == P'(1)) begin
          dos_pair <= b0m && (plain == 8'h5A);
        end
        if (bpos == P'(63)) begin
          dos_ok <= dos_pair;
        end
        if (bpos >= P'(60) && low_pos) begin
          hoff <= put_byte(hoff, bpos[1:0], plain);
        end
      end
      if (cap_en) begin
        if (near && d7 < 7'd4) begin
          if ((d7 == 7'd0 && cap_b != 8'h50) || (d7 == 7'd1 && cap_b != 8'h45) ||
              (d7 >= 7'd2 && cap_b != 8'h00)) begin
            sig <= SIG_MISMATCH;
          end else if (d7 == 7'd3 && sig != SIG_MISMATCH) begin
            sig <= SIG_MATCH;
          end
        end
        if (near && d7 == 7'd6)  scnt[7:0]  <= cap_b;
        if (near && d7 == 7'd7)  scnt[15:8] <= cap_b;
        if (near && d7 == 7'd20) ohs[7:0]   <= cap_b;
        if (near && d7 == 7'd21) ohs[15:8]  <= cap_b;
        if (near && d7 >= 7'd84) begin
          hsz <= put_byte(hsz, d7[1:0], cap_b);
        end
        if (t_in) begin
          tbl_on <= 1'b1;
          tr     <= (t_r == 6'd39) ? 6'd0 : t_r + 6'd1;
          te     <= (t_r == 6'd39 && row_ok) ? t_e + 16'd1 : t_e;
        end
        if (row_ok && t_r >= 6'd16 && t_r < 6'd20) begin
          rsz <= put_byte(rsz, 2'(t_r - 6'd16), cap_b);
        end
        if (row_ok && t_r >= 6'd20 && t_r < 6'd24) begin
          rptr <= rptr_new;
          if (t_r == 6'd23 && rptr_new != '0 && 34'(sec_end) > lse) begin
            lse <= 34'(sec_end);
          end
        end
      end
    end
  end
endmodule
